[rtl/bmg_pkg.sv]
// shared types, constants and helper functions for the box mirror ghost block
package bmg_pkg;

    localparam int MaxParticlesDef = 1048576;
    localparam int QueueDepth      = 4;
    localparam int Combos          = 27;

    localparam int SideMinus = 0;
    localparam int SideNone  = 1;
    localparam int SidePlus  = 2;

    localparam logic [31:0] BoxLowReset  = 32'hffff_0000;
    localparam logic [31:0] BoxHighReset = 32'h0001_0000;
    localparam logic [15:0] ReachReset   = 16'd512;
    localparam logic [15:0] MinGapReset  = 16'd13;

    typedef enum logic [2:0] {
        CfgBoxLowX  = 3'd0,
        CfgBoxLowY  = 3'd1,
        CfgBoxLowZ  = 3'd2,
        CfgBoxHighX = 3'd3,
        CfgBoxHighY = 3'd4,
        CfgBoxHighZ = 3'd5,
        CfgReach    = 3'd6,
        CfgMinGap   = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0][31:0] box_low;
        logic [2:0][31:0] box_high;
        logic [15:0]      reach;
        logic [15:0]      min_gap;
    } t_cfg;

    typedef struct packed {
        logic [2:0][31:0]    ghost_lo;
        logic [2:0][31:0]    pos;
        logic [2:0][31:0]    ghost_hi;
        logic [30:0]         smoothing_len;
        logic [19:0]         index;
        logic [Combos-1:0]   mask;
    } t_task;

    typedef struct packed {
        logic  valid;
        t_task data;
    } t_q_push;

    typedef struct packed {
        logic  empty;
        t_task data;
    } t_q_head;

    function automatic logic [Combos-1:0] side_mask(input int axis, input int side);
        logic [Combos-1:0] m;
        int s;
        m = '0;
        for (int k = 0; k < Combos; k++) begin
            case (axis)
                0:       s = k / 9;
                1:       s = (k / 3) % 3;
                default: s = k % 3;
            endcase
            m[k] = (s == side);
        end
        return m;
    endfunction

    localparam logic [2:0][Combos-1:0] MinusMask = {
        side_mask(2, SideMinus), side_mask(1, SideMinus), side_mask(0, SideMinus)};
    localparam logic [2:0][Combos-1:0] NoneMask = {
        side_mask(2, SideNone), side_mask(1, SideNone), side_mask(0, SideNone)};
    localparam logic [2:0][Combos-1:0] PlusMask = {
        side_mask(2, SidePlus), side_mask(1, SidePlus), side_mask(0, SidePlus)};

    function automatic logic [31:0] sat32(input logic signed [41:0] v);
        logic [31:0] r;
        if (v > 42'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -42'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/box_mirror_ghosts_core.sv]
// top level of the box mirror ghost generator
//
//  channel   | direction | handshake                   | beat
//  ----------+-----------+-----------------------------+----------------------------------
//  particle  | in        | push / full                 | position, smoothing length, index
//  ghost     | out       | empty / pop                 | ghost position, h, index, last flag
//  config    | in        | i_cfg_valid / o_cfg_ready   | register index, write data
//
// a particle beat is accepted every cycle while the ghost side keeps up; it reaches
// the emitter through the two front stages and the queue
// the emitter sends one ghost per cycle while the ghost side pops, and a particle holds it
// until all its ghosts (1 to 26) are sent; particles with no ghosts leave the front end without cost
// full rises when four particles are in flight between acceptance and the emitter
// reset is synchronous and loads the configuration defaults; config is always ready
module box_mirror_ghosts_core #(
    parameter int MAX_PARTICLES = bmg_pkg::MaxParticlesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [30:0] i_smoothing_len,
    input  logic [19:0] i_particle_index,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_ghost_x,
    output logic [31:0] o_ghost_y,
    output logic [31:0] o_ghost_z,
    output logic [30:0] o_ghost_smoothing_len,
    output logic [19:0] o_source_index,
    output logic        o_last_ghost,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    bmg_pkg::t_cfg    r_cfg;
    bmg_pkg::t_q_push w_q_push;
    bmg_pkg::t_q_head w_q_head;
    logic             w_q_pop;
    logic             w_q_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_low  <= {3{bmg_pkg::BoxLowReset}};
            r_cfg.box_high <= {3{bmg_pkg::BoxHighReset}};
            r_cfg.reach    <= bmg_pkg::ReachReset;
            r_cfg.min_gap  <= bmg_pkg::MinGapReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bmg_pkg::t_cfg_reg'(i_cfg_index))
                bmg_pkg::CfgBoxLowX: begin
                    r_cfg.box_low[0] <= i_cfg_data;
                end
                bmg_pkg::CfgBoxLowY: begin
                    r_cfg.box_low[1] <= i_cfg_data;
                end
                bmg_pkg::CfgBoxLowZ: begin
                    r_cfg.box_low[2] <= i_cfg_data;
                end
                bmg_pkg::CfgBoxHighX: begin
                    r_cfg.box_high[0] <= i_cfg_data;
                end
                bmg_pkg::CfgBoxHighY: begin
                    r_cfg.box_high[1] <= i_cfg_data;
                end
                bmg_pkg::CfgBoxHighZ: begin
                    r_cfg.box_high[2] <= i_cfg_data;
                end
                bmg_pkg::CfgReach: begin
                    r_cfg.reach <= i_cfg_data[15:0];
                end
                bmg_pkg::CfgMinGap: begin
                    r_cfg.min_gap <= i_cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    bmg_front #(
        .MAX_PARTICLES(MAX_PARTICLES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .push            (push),
        .full            (full),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_smoothing_len (i_smoothing_len),
        .i_particle_index(i_particle_index),
        .i_q_pop         (w_q_pop),
        .o_q_push        (w_q_push)
    );

    bmg_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_pop  (w_q_pop),
        .o_head (w_q_head),
        .o_full (w_q_full)
    );

    bmg_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_head               (w_q_head),
        .o_q_pop              (w_q_pop),
        .pop                  (pop),
        .empty                (empty),
        .o_ghost_x            (o_ghost_x),
        .o_ghost_y            (o_ghost_y),
        .o_ghost_z            (o_ghost_z),
        .o_ghost_smoothing_len(o_ghost_smoothing_len),
        .o_source_index       (o_source_index),
        .o_last_ghost         (o_last_ghost)
    );

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push.valid |-> !w_q_full)
        else $error("queue written while full");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_head.empty)
        else $error("queue read while empty");

    a_head_has_ghosts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_q_head.empty |-> (w_q_head.data.mask != '0))
        else $error("queued particle without ghosts");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("ghost pending after reset");

endmodule

[rtl/bmg_front.sv]
// front end: accepts particles, checks the box, builds the ghost mask and candidates
module bmg_front #(
    parameter int MAX_PARTICLES = bmg_pkg::MaxParticlesDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bmg_pkg::t_cfg    i_cfg,
    input  logic             push,
    output logic             full,
    input  logic [31:0]      i_pos_x,
    input  logic [31:0]      i_pos_y,
    input  logic [31:0]      i_pos_z,
    input  logic [30:0]      i_smoothing_len,
    input  logic [19:0]      i_particle_index,
    input  logic             i_q_pop,
    output bmg_pkg::t_q_push o_q_push
);

    localparam int OccW = $clog2(bmg_pkg::QueueDepth + 1);

    logic              w_accept;
    logic [2:0][31:0]  w_in_pos;
    logic [2:0][32:0]  w_dlo;
    logic [2:0][32:0]  w_dhi;
    logic [2:0]        w_inside;
    logic              w_idx_ok;

    logic              r_s1_v;
    logic              r_s1_ok;
    logic [46:0]       r_s1_gap_prod;
    logic [46:0]       r_s1_reach;
    logic [2:0][31:0]  r_s1_dlo;
    logic [2:0][31:0]  r_s1_dhi;
    logic [2:0][31:0]  r_s1_pos;
    logic [30:0]       r_s1_h;
    logic [19:0]       r_s1_idx;

    logic [38:0]       w_gap;
    logic [2:0][38:0]  n_s2_dlo;
    logic [2:0][38:0]  n_s2_dhi;

    logic              r_s2_v;
    logic              r_s2_ok;
    logic [46:0]       r_s2_reach;
    logic [2:0][38:0]  r_s2_dlo;
    logic [2:0][38:0]  r_s2_dhi;
    logic [2:0][31:0]  r_s2_pos;
    logic [30:0]       r_s2_h;
    logic [19:0]       r_s2_idx;

    logic [2:0]                         w_pass_lo;
    logic [2:0]                         w_pass_hi;
    logic [2:0]                         w_nz_lo;
    logic [2:0]                         w_nz_hi;
    logic                               w_reach_nz;
    logic [bmg_pkg::Combos-1:0]         w_keep;
    logic [bmg_pkg::Combos-1:0]         w_nz;
    logic [bmg_pkg::Combos-1:0]         w_mask;
    logic                               w_drop;

    logic [OccW-1:0]   r_occ;
    logic [OccW-1:0]   n_occ;

    assign w_accept = push && !full;
    assign full     = (r_occ == OccW'(bmg_pkg::QueueDepth));
    assign w_in_pos = {i_pos_z, i_pos_y, i_pos_x};
    assign w_idx_ok = ({12'd0, i_particle_index} < 32'(MAX_PARTICLES));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_dlo[k]    = {w_in_pos[k][31], w_in_pos[k]}
                        - {i_cfg.box_low[k][31], i_cfg.box_low[k]};
            w_dhi[k]    = {i_cfg.box_high[k][31], i_cfg.box_high[k]}
                        - {w_in_pos[k][31], w_in_pos[k]};
            w_inside[k] = !w_dlo[k][32] && !w_dhi[k][32];
        end
    end

    // stage 1: products, face distances, box check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= w_accept;
        end
        if (w_accept) begin
            r_s1_ok       <= w_idx_ok && (&w_inside);
            r_s1_gap_prod <= {31'd0, i_cfg.min_gap} * {16'd0, i_smoothing_len};
            r_s1_reach    <= {31'd0, i_cfg.reach} * {16'd0, i_smoothing_len};
            for (int k = 0; k < 3; k++) begin
                r_s1_dlo[k] <= w_dlo[k][31:0];
                r_s1_dhi[k] <= w_dhi[k][31:0];
            end
            r_s1_pos <= w_in_pos;
            r_s1_h   <= i_smoothing_len;
            r_s1_idx <= i_particle_index;
        end
    end

    // stage 2: floor distances at the minimum gap
    assign w_gap = r_s1_gap_prod[46:8];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s2_dlo[k] = ({7'd0, r_s1_dlo[k]} < w_gap) ? w_gap : {7'd0, r_s1_dlo[k]};
            n_s2_dhi[k] = ({7'd0, r_s1_dhi[k]} < w_gap) ? w_gap : {7'd0, r_s1_dhi[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        if (r_s1_v) begin
            r_s2_ok    <= r_s1_ok;
            r_s2_reach <= r_s1_reach;
            r_s2_dlo   <= n_s2_dlo;
            r_s2_dhi   <= n_s2_dhi;
            r_s2_pos   <= r_s1_pos;
            r_s2_h     <= r_s1_h;
            r_s2_idx   <= r_s1_idx;
        end
    end

    // reach tests, combination mask and ghost candidates
    assign w_reach_nz = (r_s2_reach != '0);

    always_comb begin
        w_keep = '1;
        w_nz   = '0;
        for (int k = 0; k < 3; k++) begin
            w_pass_lo[k] = ({r_s2_dlo[k], 8'd0} < r_s2_reach);
            w_pass_hi[k] = ({r_s2_dhi[k], 8'd0} < r_s2_reach);
            w_nz_lo[k]   = (r_s2_dlo[k] != '0);
            w_nz_hi[k]   = (r_s2_dhi[k] != '0);
            w_keep = w_keep & ((bmg_pkg::MinusMask[k] & {bmg_pkg::Combos{w_pass_lo[k]}})
                             | (bmg_pkg::NoneMask[k]  & {bmg_pkg::Combos{w_reach_nz}})
                             | (bmg_pkg::PlusMask[k]  & {bmg_pkg::Combos{w_pass_hi[k]}}));
            w_nz   = w_nz   | (bmg_pkg::MinusMask[k] & {bmg_pkg::Combos{w_nz_lo[k]}})
                            | (bmg_pkg::PlusMask[k]  & {bmg_pkg::Combos{w_nz_hi[k]}});
        end
        w_mask = w_keep & w_nz & {bmg_pkg::Combos{r_s2_ok}};
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_q_push.data.ghost_lo[k] = bmg_pkg::sat32(
                $signed({{10{r_s2_pos[k][31]}}, r_s2_pos[k]})
                - $signed({2'b00, r_s2_dlo[k], 1'b0}));
            o_q_push.data.ghost_hi[k] = bmg_pkg::sat32(
                $signed({{10{r_s2_pos[k][31]}}, r_s2_pos[k]})
                + $signed({2'b00, r_s2_dhi[k], 1'b0}));
        end
        o_q_push.data.pos           = r_s2_pos;
        o_q_push.data.smoothing_len = r_s2_h;
        o_q_push.data.index         = r_s2_idx;
        o_q_push.data.mask          = w_mask;
        o_q_push.valid              = r_s2_v && (w_mask != '0);
    end

    assign w_drop = r_s2_v && (w_mask == '0);

    // items in flight plus queued items, bounded by the queue depth
    assign n_occ = r_occ + OccW'(w_accept) - OccW'(i_q_pop) - OccW'(w_drop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

endmodule

[rtl/bmg_queue.sv]
// short first-in first-out queue between front end and ghost emitter
module bmg_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bmg_pkg::t_q_push i_push,
    input  logic             i_pop,
    output bmg_pkg::t_q_head o_head,
    output logic             o_full
);

    localparam int PtrW = $clog2(bmg_pkg::QueueDepth);
    localparam int CntW = $clog2(bmg_pkg::QueueDepth + 1);

    bmg_pkg::t_task r_mem [bmg_pkg::QueueDepth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_cnt;

    assign o_head.empty = (r_cnt == '0);
    assign o_head.data  = r_mem[r_rd_ptr];
    assign o_full       = (r_cnt == CntW'(bmg_pkg::QueueDepth));

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(bmg_pkg::QueueDepth - 1)) ? '0
                                                                          : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(bmg_pkg::QueueDepth - 1)) ? '0
                                                                          : r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + CntW'(i_push.valid) - CntW'(i_pop);
        end
    end

endmodule

[rtl/bmg_back.sv]
// back end: walks the ghost mask and emits one ghost per cycle while the ghost output is popped
module bmg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bmg_pkg::t_q_head i_head,
    output logic             o_q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [31:0]      o_ghost_x,
    output logic [31:0]      o_ghost_y,
    output logic [31:0]      o_ghost_z,
    output logic [30:0]      o_ghost_smoothing_len,
    output logic [19:0]      o_source_index,
    output logic             o_last_ghost
);

    logic                       r_cur_v;
    bmg_pkg::t_task             r_cur;
    logic                       w_emit;
    logic                       w_cur_free;
    logic [bmg_pkg::Combos-1:0] w_pick;
    logic [bmg_pkg::Combos-1:0] w_rest;
    logic [2:0][31:0]           w_coord;

    logic                       r_out_v;
    logic [2:0][31:0]           r_out_coord;
    logic [30:0]                r_out_h;
    logic [19:0]                r_out_idx;
    logic                       r_out_last;

    assign w_emit     = r_cur_v && (!r_out_v || pop);
    assign w_pick     = r_cur.mask & (~r_cur.mask + 1'b1);
    assign w_rest     = r_cur.mask & ~w_pick;
    assign w_cur_free = !r_cur_v || (w_emit && (w_rest == '0));
    assign o_q_pop    = w_cur_free && !i_head.empty;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if ((w_pick & bmg_pkg::MinusMask[k]) != '0) begin
                w_coord[k] = r_cur.ghost_lo[k];
            end else if ((w_pick & bmg_pkg::PlusMask[k]) != '0) begin
                w_coord[k] = r_cur.ghost_hi[k];
            end else begin
                w_coord[k] = r_cur.pos[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v <= 1'b0;
        end else if (o_q_pop) begin
            r_cur_v <= 1'b1;
        end else if (w_emit) begin
            r_cur_v <= (w_rest != '0);
        end
        if (o_q_pop) begin
            r_cur <= i_head.data;
        end else if (w_emit) begin
            r_cur.mask <= w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_emit) begin
            r_out_v <= 1'b1;
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
        if (w_emit) begin
            r_out_coord <= w_coord;
            r_out_h     <= r_cur.smoothing_len;
            r_out_idx   <= r_cur.index;
            r_out_last  <= (w_rest == '0);
        end
    end

    assign empty                 = !r_out_v;
    assign o_ghost_x             = r_out_coord[0];
    assign o_ghost_y             = r_out_coord[1];
    assign o_ghost_z             = r_out_coord[2];
    assign o_ghost_smoothing_len = r_out_h;
    assign o_source_index        = r_out_idx;
    assign o_last_ghost          = r_out_last;

endmodule

[bench/box_mirror_ghosts_core_test.sv]
// self-checking testbench for the box mirror ghost core
`timescale 1ns / 100ps

module box_mirror_ghosts_core_test;

    localparam int     QuietLimit = 2000;
    localparam longint Int32Max   = 64'sh0000_0000_7fff_ffff;
    localparam longint Int32Min   = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] h;
        logic [19:0] idx;
        logic        last;
    } t_ghost;

    typedef enum logic [1:0] {RowCfg, RowModel, RowNone, RowOne} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        bmg_pkg::t_cfg_reg reg_sel;
        logic [31:0]       a;
        logic [31:0]       b;
        logic [31:0]       c;
        logic [30:0]       h;
        logic [19:0]       idx;
        logic [31:0]       gx;
        logic [31:0]       gy;
        logic [31:0]       gz;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [31:0] i_pos_x;
    logic [31:0] i_pos_y;
    logic [31:0] i_pos_z;
    logic [30:0] i_smoothing_len;
    logic [19:0] i_particle_index;
    logic        empty;
    logic        pop;
    logic [31:0] o_ghost_x;
    logic [31:0] o_ghost_y;
    logic [31:0] o_ghost_z;
    logic [30:0] o_ghost_smoothing_len;
    logic [19:0] o_source_index;
    logic        o_last_ghost;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    logic [31:0] box_low[3]  = '{bmg_pkg::BoxLowReset, bmg_pkg::BoxLowReset,
                                 bmg_pkg::BoxLowReset};
    logic [31:0] box_high[3] = '{bmg_pkg::BoxHighReset, bmg_pkg::BoxHighReset,
                                 bmg_pkg::BoxHighReset};
    logic [15:0] reach       = bmg_pkg::ReachReset;
    logic [15:0] min_gap     = bmg_pkg::MinGapReset;

    t_ghost ghosts_due[$];
    t_ghost next_ghost;
    int     failures        = 0;
    int     ghosts_checked  = 0;
    int     particles_sent  = 0;
    int     ghostless       = 0;
    int     settings_used   = 1;
    int     idle_cycles     = 0;
    bit     send_burst      = 0;
    bit     take_burst      = 0;

    box_mirror_ghosts_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .push                  (push),
        .full                  (full),
        .i_pos_x               (i_pos_x),
        .i_pos_y               (i_pos_y),
        .i_pos_z               (i_pos_z),
        .i_smoothing_len       (i_smoothing_len),
        .i_particle_index      (i_particle_index),
        .empty                 (empty),
        .pop                   (pop),
        .o_ghost_x             (o_ghost_x),
        .o_ghost_y             (o_ghost_y),
        .o_ghost_z             (o_ghost_z),
        .o_ghost_smoothing_len (o_ghost_smoothing_len),
        .o_source_index        (o_source_index),
        .o_last_ghost          (o_last_ghost),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int predict_ghosts(input logic [31:0] px, input logic [31:0] py,
                                          input logic [31:0] pz, input logic [30:0] h,
                                          input logic [19:0] idx);
        longint pos[3];
        longint lo[3];
        longint hi[3];
        longint dlo[3];
        longint dhi[3];
        longint off[3];
        longint spot[3];
        longint gap;
        longint lim;
        longint mag;
        int     side[3];
        int     made;
        bit     keep;
        t_ghost g;
        made = 0;
        pos[0] = longint'($signed(px));
        pos[1] = longint'($signed(py));
        pos[2] = longint'($signed(pz));
        for (int k = 0; k < 3; k++) begin
            lo[k] = longint'($signed(box_low[k]));
            hi[k] = longint'($signed(box_high[k]));
        end
        if (longint'(idx) >= longint'(bmg_pkg::MaxParticlesDef)) return 0;
        for (int k = 0; k < 3; k++) begin
            if (pos[k] < lo[k] || pos[k] > hi[k]) return 0;
        end
        gap = (longint'(min_gap) * longint'(h)) >>> 8;
        lim = longint'(reach) * longint'(h);
        for (int k = 0; k < 3; k++) begin
            dlo[k] = pos[k] - lo[k];
            dhi[k] = hi[k] - pos[k];
            if (dlo[k] < gap) dlo[k] = gap;
            if (dhi[k] < gap) dhi[k] = gap;
        end
        // x outermost, minus before none before plus
        for (int combo = 0; combo < bmg_pkg::Combos; combo++) begin
            side[0] = combo / 9;
            side[1] = (combo / 3) % 3;
            side[2] = combo % 3;
            keep = 1'b1;
            for (int k = 0; k < 3; k++) begin
                case (side[k])
                    bmg_pkg::SideMinus: begin
                        mag    = dlo[k];
                        off[k] = -dlo[k];
                    end
                    bmg_pkg::SidePlus: begin
                        mag    = dhi[k];
                        off[k] = dhi[k];
                    end
                    default: begin
                        mag    = 0;
                        off[k] = 0;
                    end
                endcase
                if ((mag <<< 8) >= lim) keep = 1'b0;
            end
            if (keep && (off[0] != 0 || off[1] != 0 || off[2] != 0)) begin
                for (int k = 0; k < 3; k++) begin
                    spot[k] = pos[k] + 2 * off[k];
                    if (spot[k] > Int32Max) spot[k] = Int32Max;
                    if (spot[k] < Int32Min) spot[k] = Int32Min;
                end
                g.x    = 32'(spot[0]);
                g.y    = 32'(spot[1]);
                g.z    = 32'(spot[2]);
                g.h    = h;
                g.idx  = idx;
                g.last = 1'b0;
                ghosts_due.push_back(g);
                made++;
            end
        end
        if (made > 0) ghosts_due[ghosts_due.size() - 1].last = 1'b1;
        return made;
    endfunction

    function automatic logic [31:0] pick_coord(input int axis, input logic [30:0] h);
        longint lo;
        longint hi;
        longint v;
        int     mode;
        lo   = longint'($signed(box_low[axis]));
        hi   = longint'($signed(box_high[axis]));
        mode = $urandom_range(0, 9);
        if (hi < lo || mode == 9) return $urandom;
        case (mode)
            5, 6: begin
                v = lo + longint'((longint'(h) * $urandom_range(0, 1023)) >>> 8);
                if (v > hi) v = hi;
            end
            7: begin
                v = hi - longint'((longint'(h) * $urandom_range(0, 1023)) >>> 8);
                if (v < lo) v = lo;
            end
            8: v = $urandom_range(0, 1) ? lo : hi;
            default: v = lo + (hi - lo) * longint'($urandom_range(0, 65535)) / 65535;
        endcase
        return 32'(v);
    endfunction

    function automatic t_row particle_row(input t_row_kind kind, input logic [31:0] px,
                                          input logic [31:0] py, input logic [31:0] pz,
                                          input logic [30:0] h, input logic [19:0] idx,
                                          input logic [31:0] gx = '0,
                                          input logic [31:0] gy = '0,
                                          input logic [31:0] gz = '0);
        t_row r;
        r.kind    = kind;
        r.reg_sel = bmg_pkg::CfgBoxLowX;
        r.a       = px;
        r.b       = py;
        r.c       = pz;
        r.h       = h;
        r.idx     = idx;
        r.gx      = gx;
        r.gy      = gy;
        r.gz      = gz;
        return r;
    endfunction

    function automatic t_row register_row(input bmg_pkg::t_cfg_reg sel,
                                          input logic [31:0] value);
        t_row r;
        r         = particle_row(RowCfg, value, '0, '0, '0, '0);
        r.reg_sel = sel;
        return r;
    endfunction

    task automatic write_reg(input bmg_pkg::t_cfg_reg sel, input logic [31:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = sel;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (sel)
            bmg_pkg::CfgBoxLowX:  box_low[0]  = value;
            bmg_pkg::CfgBoxLowY:  box_low[1]  = value;
            bmg_pkg::CfgBoxLowZ:  box_low[2]  = value;
            bmg_pkg::CfgBoxHighX: box_high[0] = value;
            bmg_pkg::CfgBoxHighY: box_high[1] = value;
            bmg_pkg::CfgBoxHighZ: box_high[2] = value;
            bmg_pkg::CfgReach:    reach       = value[15:0];
            bmg_pkg::CfgMinGap:   min_gap     = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic send_particle(input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] pz, input logic [30:0] h,
                                 input logic [19:0] idx, input bit predicted);
        int gap_cycles;
        gap_cycles = send_burst ? 0 : $urandom_range(0, 14);
        if (gap_cycles > 0) begin
            push = 1'b0;
            repeat (gap_cycles) @(negedge i_clk);
        end
        push             = 1'b1;
        i_pos_x          = px;
        i_pos_y          = py;
        i_pos_z          = pz;
        i_smoothing_len  = h;
        i_particle_index = idx;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        particles_sent++;
        if (predicted) begin
            if (predict_ghosts(px, py, pz, h, idx) == 0) ghostless++;
        end
    endtask

    // drain every ghost, then cover particles still in the front stages
    task automatic settle();
        push = 1'b0;
        while (ghosts_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (ghosts_due.size() == 0) begin
                $display("%0t: unexpected ghost x=%h y=%h z=%h index=%h", $time,
                         o_ghost_x, o_ghost_y, o_ghost_z, o_source_index);
                failures++;
            end else begin
                next_ghost = ghosts_due.pop_front();
                compare_field("ghost_x", next_ghost.x, o_ghost_x);
                compare_field("ghost_y", next_ghost.y, o_ghost_y);
                compare_field("ghost_z", next_ghost.z, o_ghost_z);
                compare_field("ghost_smoothing_len", next_ghost.h, o_ghost_smoothing_len);
                compare_field("source_index", next_ghost.idx, o_source_index);
                compare_field("last_ghost", next_ghost.last, o_last_ghost);
                ghosts_checked++;
            end
        end
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= QuietLimit) begin
            $display("%0t: no beat for %0d cycles, %0d ghosts outstanding", $time,
                     idle_cycles, ghosts_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : ghost_sink
        int hold;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = take_burst ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
                pop = 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_row        plan[$];
        int          mode;
        longint      lo;
        logic [31:0] rlo[3];
        logic [31:0] rhi[3];
        logic [30:0] h;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;

        i_rst_n          = 1'b0;
        push             = 1'b0;
        i_pos_x          = '0;
        i_pos_y          = '0;
        i_pos_z          = '0;
        i_smoothing_len  = '0;
        i_particle_index = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = bmg_pkg::CfgBoxLowX;
        i_cfg_data       = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset box: single plus-x ghost near the upper x face
        plan.push_back(particle_row(RowOne, 32'h0000_c000, '0, '0, 31'h0000_4000, 20'd5,
                                    32'h0001_4000, '0, '0));
        plan.push_back(particle_row(RowNone, 32'h0001_0001, '0, '0, 31'h0001_0000, 20'd6));
        plan.push_back(particle_row(RowNone, '0, 32'hfffe_ffff, '0, 31'h0001_0000, 20'd7));
        plan.push_back(particle_row(RowNone, '0, '0, '0, '0, 20'd8));
        plan.push_back(particle_row(RowModel, '0, '0, '0, 31'h0001_0000, 20'd9));
        plan.push_back(particle_row(RowModel, 32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
                                    31'h0000_8000, 20'd0));
        plan.push_back(particle_row(RowModel, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                    31'h0001_0000, 20'hfffff));
        plan.push_back(particle_row(RowNone, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    31'h7fff_ffff, 20'd1));
        plan.push_back(particle_row(RowNone, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                    31'h7fff_ffff, 20'd2));
        plan.push_back(particle_row(RowModel, '0, '0, '0, 31'h7fff_ffff, 20'd3));
        // zero minimum gap, particles on faces and a corner
        plan.push_back(register_row(bmg_pkg::CfgMinGap, 32'd0));
        plan.push_back(particle_row(RowModel, 32'hffff_0000, '0, '0, 31'h0001_0000, 20'd4));
        plan.push_back(particle_row(RowModel, 32'hffff_0000, 32'hffff_0000, 32'h0001_0000,
                                    31'h0002_0000, 20'd10));
        plan.push_back(register_row(bmg_pkg::CfgReach, 32'd0));
        plan.push_back(particle_row(RowNone, '0, '0, '0, 31'h7fff_ffff, 20'd11));
        // widest box, largest factors, saturating ghosts
        plan.push_back(register_row(bmg_pkg::CfgBoxLowX, 32'h8000_0000));
        plan.push_back(register_row(bmg_pkg::CfgBoxLowY, 32'h8000_0000));
        plan.push_back(register_row(bmg_pkg::CfgBoxLowZ, 32'h8000_0000));
        plan.push_back(register_row(bmg_pkg::CfgBoxHighX, 32'h7fff_ffff));
        plan.push_back(register_row(bmg_pkg::CfgBoxHighY, 32'h7fff_ffff));
        plan.push_back(register_row(bmg_pkg::CfgBoxHighZ, 32'h7fff_ffff));
        plan.push_back(register_row(bmg_pkg::CfgReach, 32'h0000_ffff));
        plan.push_back(register_row(bmg_pkg::CfgMinGap, 32'h0000_ffff));
        plan.push_back(particle_row(RowModel, 32'h7fff_ffff, 32'h8000_0000, '0,
                                    31'h7fff_ffff, 20'd12));
        plan.push_back(particle_row(RowModel, '0, '0, '0, 31'd1, 20'd13));
        plan.push_back(particle_row(RowModel, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    31'h0000_0100, 20'd14));
        plan.push_back(register_row(bmg_pkg::CfgMinGap, 32'd0));
        plan.push_back(particle_row(RowModel, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                    31'h7fff_ffff, 20'd15));
        // inverted x range
        plan.push_back(register_row(bmg_pkg::CfgBoxLowX, 32'h0001_0000));
        plan.push_back(register_row(bmg_pkg::CfgBoxHighX, 32'hffff_0000));
        plan.push_back(particle_row(RowNone, '0, '0, '0, 31'h0001_0000, 20'd16));
        plan.push_back(particle_row(RowNone, 32'h0001_0000, '0, '0, 31'h0001_0000, 20'd17));

        foreach (plan[i]) begin
            case (plan[i].kind)
                RowCfg: begin
                    if (!i_cfg_valid) begin
                        settle();
                        settings_used++;
                    end
                    write_reg(plan[i].reg_sel, plan[i].a);
                end
                default: begin
                    i_cfg_valid = 1'b0;
                    if (plan[i].kind == RowOne) begin
                        ghosts_due.push_back('{plan[i].gx, plan[i].gy, plan[i].gz,
                                               plan[i].h, plan[i].idx, 1'b1});
                    end
                    send_particle(plan[i].a, plan[i].b, plan[i].c, plan[i].h, plan[i].idx,
                                  plan[i].kind == RowModel);
                end
            endcase
        end

        for (int phase = 0; phase < 6; phase++) begin
            settle();
            settings_used++;
            mode = $urandom_range(0, 9);
            for (int k = 0; k < 3; k++) begin
                if (mode < 2) begin
                    rlo[k] = bmg_pkg::BoxLowReset;
                    rhi[k] = bmg_pkg::BoxHighReset;
                end else if (mode < 8) begin
                    lo     = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
                    rlo[k] = 32'(lo);
                    rhi[k] = 32'(lo + longint'($urandom_range(1, 1 << 21)));
                end else if (mode == 8) begin
                    rlo[k] = 32'h8000_0000;
                    rhi[k] = 32'h7fff_ffff;
                end else begin
                    rlo[k] = $urandom;
                    rhi[k] = $urandom;
                end
            end
            write_reg(bmg_pkg::CfgBoxLowX, rlo[0]);
            write_reg(bmg_pkg::CfgBoxLowY, rlo[1]);
            write_reg(bmg_pkg::CfgBoxLowZ, rlo[2]);
            write_reg(bmg_pkg::CfgBoxHighX, rhi[0]);
            write_reg(bmg_pkg::CfgBoxHighY, rhi[1]);
            write_reg(bmg_pkg::CfgBoxHighZ, rhi[2]);
            write_reg(bmg_pkg::CfgReach,
                      (mode >= 8) ? $urandom_range(0, 65535) : $urandom_range(0, 1023));
            write_reg(bmg_pkg::CfgMinGap,
                      (mode >= 8) ? $urandom_range(0, 65535) : $urandom_range(0, 63));
            i_cfg_valid = 1'b0;
            send_burst  = ($urandom_range(0, 3) == 0);
            take_burst  = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 30; n++) begin
                h = 31'($urandom >> $urandom_range(1, 31));
                if ($urandom_range(0, 19) == 0) h = '0;
                px = pick_coord(0, h);
                py = pick_coord(1, h);
                pz = pick_coord(2, h);
                send_particle(px, py, pz, h, 20'($urandom_range(0, 1048575)), 1'b1);
            end
        end

        push = 1'b0;
        while (ghosts_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("%0d particles across %0d register settings, %0d predicted to make no ghost",
                 particles_sent, settings_used, ghostless);
        $display("%0d ghost beats compared field by field", ghosts_checked);
        if (failures == 0 && ghosts_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[box_mirror_ghosts_core.f]
rtl/bmg_pkg.sv
rtl/bmg_front.sv
rtl/bmg_queue.sv
rtl/bmg_back.sv
rtl/box_mirror_ghosts_core.sv
bench/box_mirror_ghosts_core_test.sv
